// ===== design/srecp_pkg.sv =====
// Shared types, constants and program labels for the S1 line packer.
`timescale 1ns / 1ps

package srecp_pkg;

    // Largest number of data bytes in one S1 line.
    localparam int BYTES_PER_LINE_DEF = 16;

    // Width of the program counter and entry points of the program.
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_IDLE  = 6'd0;
    localparam logic [PC_W-1:0] PC_STORE = 6'd5;
    localparam logic [PC_W-1:0] PC_TERM  = 6'd8;
    localparam logic [PC_W-1:0] PC_S9    = 6'd9;
    localparam logic [PC_W-1:0] PC_LINE  = 6'd20;
    localparam logic [PC_W-1:0] PC_LOOP  = 6'd29;
    localparam logic [PC_W-1:0] PC_LRET  = 6'd34;

    // Operation codes of an input item.
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_TERM = 2'd1;

    // ASCII characters used by the program.
    localparam logic [6:0] CH_S_CODE  = 7'h53;
    localparam logic [6:0] CH_1_CODE  = 7'h31;
    localparam logic [6:0] CH_9_CODE  = 7'h39;
    localparam logic [6:0] CH_0_CODE  = 7'h30;
    localparam logic [6:0] CH_3_CODE  = 7'h33;
    localparam logic [6:0] CH_F_CODE  = 7'h46;
    localparam logic [6:0] CH_C_CODE  = 7'h43;
    localparam logic [6:0] CH_NL_CODE = 7'h0A;

    // Source of the character sent in one step.
    typedef enum logic [3:0] {
        CS_LIT,
        CS_CNT_HI,
        CS_CNT_LO,
        CS_AH_HI,
        CS_AH_LO,
        CS_AL_HI,
        CS_AL_LO,
        CS_DAT_HI,
        CS_DAT_LO,
        CS_SUM_HI,
        CS_SUM_LO
    } csel_t;

    // How the end-of-item mark is set on a sent character.
    typedef enum logic [1:0] {
        LS_NONE,
        LS_ONE,
        LS_LINE
    } last_sel_t;

    // Datapath action of one step.
    typedef enum logic [3:0] {
        A_NOP,
        A_LATCH,
        A_CMP,
        A_STORE,
        A_SET_FINAL,
        A_SET_TERM,
        A_LINE_INIT,
        A_READ,
        A_NEXT,
        A_LINE_DONE
    } act_t;

    // Jump condition of one step.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_OP_TERM,
        C_OP_OTHER,
        C_CONTIG,
        C_NOT_FULL,
        C_EMPTY,
        C_MORE_DATA,
        C_RET_STORE,
        C_RET_TERM
    } cond_t;

    // Where the line routine goes back to when it ends.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_STORE,
        RET_TERM
    } ret_t;

    // One control word of the program.
    typedef struct packed {
        logic            emit;
        csel_t           csel;
        logic [6:0]      lit;
        last_sel_t       last_sel;
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Datapath status flags seen by the sequencer.
    typedef struct packed {
        logic op_term;
        logic op_other;
        logic contig;
        logic not_full;
        logic empty;
        logic more_data;
        logic ret_store;
        logic ret_term;
        logic more_lines;
    } status_t;

    // Upper-case hex digit of a nibble.
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10)
        begin
            ch = 7'h30 + {3'b000, nib};
        end
        else
        begin
            ch = 7'h37 + {3'b000, nib};
        end
        return ch;
    endfunction

endpackage

// ===== design/srecp_ucode_rom.sv =====
// Program store of the sequencer: one control word per step.
`timescale 1ns / 1ps

module srecp_ucode_rom
    import srecp_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ctrl_t           ctrl
);

    // Builds one control word.
    function automatic ctrl_t cw(input logic e, input csel_t cs, input logic [6:0] lit,
                                 input last_sel_t ls, input act_t a, input cond_t c,
                                 input logic [PC_W-1:0] tgt);
        ctrl_t w;
        w.emit     = e;
        w.csel     = cs;
        w.lit      = lit;
        w.last_sel = ls;
        w.act      = a;
        w.cond     = c;
        w.target   = tgt;
        return w;
    endfunction

    // The program. Unlisted steps fall back to the idle step.
    always_comb
    begin
        unique case (pc)
            // Wait for an item and capture it.
            6'd0:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_LATCH, C_NO_INPUT, PC_IDLE);
            6'd1:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_OP_TERM, PC_TERM);
            6'd2:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_OP_OTHER, PC_IDLE);
            // Data byte: flush the pending run if the address breaks it.
            6'd3:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_CMP, C_CONTIG, PC_STORE);
            6'd4:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_ALWAYS, PC_LINE);
            6'd5:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_STORE, C_NEVER, PC_IDLE);
            6'd6:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_NOT_FULL, PC_IDLE);
            6'd7:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_SET_FINAL, C_ALWAYS, PC_LINE);
            // Termination: flush, then the fixed S9 line.
            6'd8:  ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_SET_TERM, C_ALWAYS, PC_LINE);
            6'd9:  ctrl = cw(1'b1, CS_LIT, CH_S_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd10: ctrl = cw(1'b1, CS_LIT, CH_9_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd11: ctrl = cw(1'b1, CS_LIT, CH_0_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd12: ctrl = cw(1'b1, CS_LIT, CH_3_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd13: ctrl = cw(1'b1, CS_LIT, CH_0_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd14: ctrl = cw(1'b1, CS_LIT, CH_0_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd15: ctrl = cw(1'b1, CS_LIT, CH_0_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd16: ctrl = cw(1'b1, CS_LIT, CH_0_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd17: ctrl = cw(1'b1, CS_LIT, CH_F_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd18: ctrl = cw(1'b1, CS_LIT, CH_C_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd19: ctrl = cw(1'b1, CS_LIT, CH_NL_CODE, LS_ONE, A_NOP, C_ALWAYS, PC_IDLE);
            // Line routine: header, data bytes, checksum, newline.
            6'd20: ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_LINE_INIT, C_EMPTY, PC_LRET);
            6'd21: ctrl = cw(1'b1, CS_LIT, CH_S_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd22: ctrl = cw(1'b1, CS_LIT, CH_1_CODE, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd23: ctrl = cw(1'b1, CS_CNT_HI, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd24: ctrl = cw(1'b1, CS_CNT_LO, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd25: ctrl = cw(1'b1, CS_AH_HI, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd26: ctrl = cw(1'b1, CS_AH_LO, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd27: ctrl = cw(1'b1, CS_AL_HI, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd28: ctrl = cw(1'b1, CS_AL_LO, 7'd0, LS_NONE, A_READ, C_NEVER, PC_IDLE);
            6'd29: ctrl = cw(1'b1, CS_DAT_HI, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd30: ctrl = cw(1'b1, CS_DAT_LO, 7'd0, LS_NONE, A_NEXT, C_MORE_DATA, PC_LOOP);
            6'd31: ctrl = cw(1'b1, CS_SUM_HI, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd32: ctrl = cw(1'b1, CS_SUM_LO, 7'd0, LS_NONE, A_NOP, C_NEVER, PC_IDLE);
            6'd33: ctrl = cw(1'b1, CS_LIT, CH_NL_CODE, LS_LINE, A_LINE_DONE, C_NEVER,
                             PC_IDLE);
            // Return from the line routine.
            6'd34: ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_RET_STORE, PC_STORE);
            6'd35: ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_RET_TERM, PC_S9);
            6'd36: ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_ALWAYS, PC_IDLE);
            default: ctrl = cw(1'b0, CS_LIT, 7'd0, LS_NONE, A_NOP, C_ALWAYS, PC_IDLE);
        endcase
    end

endmodule

// ===== design/srecp_datapath.sv =====
// Datapath: item capture, line buffer, address and count, checksum, character select.
`timescale 1ns / 1ps

module srecp_datapath
    import srecp_pkg::*;
#(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    input  logic        step,
    input  logic [1:0]  in_operation,
    input  logic [15:0] in_address,
    input  logic [7:0]  in_data_byte,
    output status_t     status,
    output logic [6:0]  character
);

    localparam int FILL_W = $clog2(BYTES_PER_LINE + 1);
    localparam int IDX_W  = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
    localparam int DEPTH  = 2 ** IDX_W;

    // Captured item.
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  byte_reg;

    // Run state and line working registers.
    logic [15:0]       line_addr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] idx_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        rd_reg;
    logic              contig_reg;
    logic              more_reg;
    ret_t              ret_reg;

    logic [7:0] buf_mem [DEPTH];

    logic              contig;
    logic [7:0]        count;
    logic [FILL_W-1:0] idx_inc;

    // Run continues only without 16-bit wrap of the next address.
    assign contig  = (({1'b0, line_addr_reg} + 17'(fill_reg)) == {1'b0, addr_reg});
    assign count   = 8'(fill_reg) + 8'd3;
    assign idx_inc = idx_reg + 1'b1;

    // Status flags for jump conditions.
    always_comb
    begin
        status.op_term    = (op_reg == OP_TERM);
        status.op_other   = (op_reg != OP_DATA);
        status.contig     = contig;
        status.not_full   = (fill_reg != FILL_W'(BYTES_PER_LINE));
        status.empty      = (fill_reg == '0);
        status.more_data  = (idx_inc < fill_reg);
        status.ret_store  = (ret_reg == RET_STORE);
        status.ret_term   = (ret_reg == RET_TERM);
        status.more_lines = more_reg;
    end

    // Character selection for the current step.
    always_comb
    begin
        unique case (ctrl.csel)
            CS_LIT:    character = ctrl.lit;
            CS_CNT_HI: character = hex_char(count[7:4]);
            CS_CNT_LO: character = hex_char(count[3:0]);
            CS_AH_HI:  character = hex_char(line_addr_reg[15:12]);
            CS_AH_LO:  character = hex_char(line_addr_reg[11:8]);
            CS_AL_HI:  character = hex_char(line_addr_reg[7:4]);
            CS_AL_LO:  character = hex_char(line_addr_reg[3:0]);
            CS_DAT_HI: character = hex_char(rd_reg[7:4]);
            CS_DAT_LO: character = hex_char(rd_reg[3:0]);
            CS_SUM_HI: character = hex_char(~sum_reg[7:4]);
            CS_SUM_LO: character = hex_char(~sum_reg[3:0]);
            default:   character = ctrl.lit;
        endcase
    end

    // Control registers of the run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_addr_reg <= '0;
            fill_reg      <= '0;
            ret_reg       <= RET_IDLE;
            more_reg      <= 1'b0;
            contig_reg    <= 1'b0;
        end
        else if (step)
        begin
            unique case (ctrl.act)
                A_CMP:
                begin
                    contig_reg <= contig;
                    ret_reg    <= RET_STORE;
                    more_reg   <= (BYTES_PER_LINE == 1);
                end
                A_STORE:
                begin
                    if (!contig_reg)
                    begin
                        line_addr_reg <= addr_reg;
                    end
                    fill_reg <= fill_reg + 1'b1;
                end
                A_SET_FINAL:
                begin
                    ret_reg  <= RET_IDLE;
                    more_reg <= 1'b0;
                end
                A_SET_TERM:
                begin
                    ret_reg  <= RET_TERM;
                    more_reg <= 1'b1;
                end
                A_LINE_DONE:
                begin
                    line_addr_reg <= line_addr_reg + 16'(fill_reg);
                    fill_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers, line buffer writes and registered buffer reads.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            unique case (ctrl.act)
                A_LATCH:
                begin
                    op_reg   <= in_operation;
                    addr_reg <= in_address;
                    byte_reg <= in_data_byte;
                end
                A_STORE:
                begin
                    buf_mem[fill_reg[IDX_W-1:0]] <= byte_reg;
                end
                A_LINE_INIT:
                begin
                    idx_reg <= '0;
                    sum_reg <= count + line_addr_reg[15:8] + line_addr_reg[7:0];
                end
                A_READ:
                begin
                    rd_reg <= buf_mem[idx_reg[IDX_W-1:0]];
                end
                A_NEXT:
                begin
                    sum_reg <= sum_reg + rd_reg;
                    idx_reg <= idx_inc;
                    rd_reg  <= buf_mem[idx_inc[IDX_W-1:0]];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== design/srec_line_packer_core.sv =====
// Top level of the S1 line packer: sequencer, program store, datapath and output register.
`timescale 1ns / 1ps

// Packs addressed load-image bytes into Motorola S1 text lines of up to BYTES_PER_LINE
// data bytes and sends the text one ASCII character per transfer on the master side,
// with tlast on the final character each input item causes. A line is written out
// when it is full or when a byte's address does not follow the pending run (compared
// without 16-bit wrap); a termination item writes out pending bytes and then the fixed
// S9 line; other operation codes produce nothing. A microcoded sequencer steps through
// a fixed program, one step per clock unless a sending step stalls, and sends at most
// one character per clock. A sending step stalls while the receiver holds off a waiting
// character. Writing out a line of n bytes sends 2n + 11 characters.
// The output register lets the next item be taken while the last character waits.
module srec_line_packer_core
    import srecp_pkg::*;
#(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address [15:0], data_byte [23:16]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character [6:0], zero [7]
    output logic        m_tlast
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_t           ctrl;
    status_t         status;
    logic [6:0]      character;
    logic            step;
    logic            jump;
    logic            last_bit;

    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;

    srecp_ucode_rom u_rom
    (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    srecp_datapath
    #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .step         (step),
        .in_operation (s_tuser),
        .in_address   (s_tdata[15:0]),
        .in_data_byte (s_tdata[23:16]),
        .status       (status),
        .character    (character)
    );

    // A sending step waits while the output register is full and the receiver is not ready.
    assign step     = !(ctrl.emit && out_valid_reg && !m_tready);
    assign s_tready = (pc_reg == PC_IDLE);

    // Jump condition select.
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_INPUT:  jump = !s_tvalid;
            C_OP_TERM:   jump = status.op_term;
            C_OP_OTHER:  jump = status.op_other;
            C_CONTIG:    jump = status.contig;
            C_NOT_FULL:  jump = status.not_full;
            C_EMPTY:     jump = status.empty;
            C_MORE_DATA: jump = status.more_data;
            C_RET_STORE: jump = status.ret_store;
            C_RET_TERM:  jump = status.ret_term;
            default:     jump = 1'b0;
        endcase
    end

    // Next step of the program.
    always_comb
    begin
        if (!step)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // End-of-item mark of the character being sent.
    always_comb
    begin
        unique case (ctrl.last_sel)
            LS_NONE: last_bit = 1'b0;
            LS_ONE:  last_bit = 1'b1;
            LS_LINE: last_bit = !status.more_lines;
            default: last_bit = 1'b0;
        endcase
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Output register: loads a character when a sending step proceeds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit && step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.emit && step)
        begin
            out_char_reg <= character;
            out_last_reg <= last_bit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/tb_srec_line_packer_core.sv =====
// Self-checking testbench for the S1 line packer core with a built-in line encoder.
`timescale 1ns / 1ps

module tb_srec_line_packer_core;

    import srecp_pkg::*;

    localparam int LINE_BYTES   = BYTES_PER_LINE_DEF;
    localparam int TOTAL_ITEMS  = 430;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;

    // Operation codes that the block ignores.
    localparam logic [1:0] OP_OTHER = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Extra ASCII characters needed for hex digits.
    localparam logic [6:0] CH_A_CODE = 7'h41;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
    } load_item_t;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // address [15:0], data_byte [23:16]
    logic [1:0]  s_tuser = '0;   // operation [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // character [6:0], zero [7]
    logic        m_tlast;

    // Stimulus and expected text.
    load_item_t pending_items[$];
    text_char_t expected_text[$];
    load_item_t drive_item;
    load_item_t taken_item;

    // Encoder state kept by the testbench.
    logic [7:0]  line_bytes[LINE_BYTES];
    logic [15:0] run_base;
    logic [4:0]  fill_level;

    int  error_count = 0;
    int  accepted_items = 0;
    int  cycle_count = 0;
    int  stim_count = 0;
    logic in_xfer = 1'b0;
    logic hold_off = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int  mode_left = 0;

    srec_line_packer_core #(
        .BYTES_PER_LINE(LINE_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_char(input logic [6:0] ch);
        text_char_t c;
        c.ch = ch;
        c.last = 1'b0;
        expected_text.push_back(c);
    endtask

    function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
        if (nib >= 4'd10)
        begin
            return CH_A_CODE + 7'(nib - 4'd10);
        end
        return CH_0_CODE + 7'(nib);
    endfunction

    task automatic push_hex(input logic [7:0] v);
        push_char(nibble_ascii(v[7:4]));
        push_char(nibble_ascii(v[3:0]));
    endtask

    // Writes the pending run out as one S1 line; nothing when the run is empty.
    task automatic flush_line();
        logic [7:0] count_byte;
        logic [7:0] checksum;
        int n;
        n = fill_level;
        if (n == 0)
        begin
            return;
        end
        count_byte = 8'(n + 3);
        checksum = count_byte + run_base[15:8] + run_base[7:0];
        push_char(CH_S_CODE);
        push_char(CH_1_CODE);
        push_hex(count_byte);
        push_hex(run_base[15:8]);
        push_hex(run_base[7:0]);
        for (int i = 0; i < n; i++)
        begin
            push_hex(line_bytes[i]);
            checksum = checksum + line_bytes[i];
        end
        push_hex(~checksum);
        push_char(CH_NL_CODE);
        run_base = run_base + 16'(n);
        fill_level = '0;
    endtask

    // Works out the text that one accepted item produces.
    task automatic encode_item(input load_item_t it);
        int start_size;
        start_size = expected_text.size();
        if (it.op == OP_DATA)
        begin
            // The run continues only if the address follows on, with no 16-bit wrap.
            if ({1'b0, it.addr} != ({1'b0, run_base} + {12'd0, fill_level}))
            begin
                flush_line();
                run_base = it.addr;
            end
            line_bytes[fill_level[3:0]] = it.data;
            fill_level = fill_level + 5'd1;
            if (fill_level >= LINE_BYTES)
            begin
                flush_line();
            end
        end
        else if (it.op == OP_TERM)
        begin
            flush_line();
            push_char(CH_S_CODE);
            push_char(CH_9_CODE);
            push_char(CH_0_CODE);
            push_char(CH_3_CODE);
            push_char(CH_0_CODE);
            push_char(CH_0_CODE);
            push_char(CH_0_CODE);
            push_char(CH_0_CODE);
            push_char(CH_F_CODE);
            push_char(CH_C_CODE);
            push_char(CH_NL_CODE);
        end
        if (expected_text.size() > start_size)
        begin
            expected_text[expected_text.size() - 1].last = 1'b1;
        end
    endtask

    task automatic add_item(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data);
        load_item_t it;
        it.op = op;
        it.addr = addr;
        it.data = data;
        pending_items.push_back(it);
        if (op == OP_DATA || op == OP_TERM)
        begin
            stim_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !in_xfer)
        begin
            // Hold the offered item until it is taken.
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            drive_item = pending_items.pop_front();
            s_tuser  <= drive_item.op;
            s_tdata  <= {drive_item.data, drive_item.addr};
            s_tvalid <= 1'b1;
            if (burst_left > 1)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall pattern that changes mode every so often.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(5, 60);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    // Long receiver hold-off once traffic is flowing, so the block backs up.
    initial
    begin
        @(posedge rst_n);
        while (accepted_items < 40)
        begin
            @(posedge clk);
        end
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Input transfers feed the encoder; output transfers are checked in order.
    always @(posedge clk)
    begin
        in_xfer <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            taken_item.op = s_tuser;
            taken_item.addr = s_tdata[15:0];
            taken_item.data = s_tdata[23:16];
            encode_item(taken_item);
            accepted_items++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                text_char_t want;
                want = expected_text.pop_front();
                if (m_tdata[6:0] !== want.ch)
                begin
                    report_mismatch($sformatf("character got 0x%02h expected 0x%02h",
                                              m_tdata[6:0], want.ch));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch($sformatf("last got %0b expected %0b on 0x%02h",
                                              m_tlast, want.last, want.ch));
                end
                if (m_tdata[7] !== 1'b0)
                begin
                    report_mismatch("tdata pad bit not zero");
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] next_addr;
        logic [15:0] addr;
        int roll;
        int run_len;
        run_base = '0;
        fill_level = '0;
        next_addr = '0;

        // Directed: a full line running up to the top of the address space.
        for (int i = 0; i < 16; i++)
        begin
            add_item(OP_DATA, 16'hFFF0 + 16'(i), 8'(i * 17));
        end
        // After the full line the run base has wrapped to zero, so this follows on.
        add_item(OP_DATA, 16'h0000, 8'hFF);
        add_item(OP_OTHER, 16'hFFFF, 8'hFF);
        add_item(OP_SPARE, 16'h5A5A, 8'hA5);
        // Address break at the top, then a run that would only continue with wrap.
        add_item(OP_DATA, 16'hFFFF, 8'h00);
        add_item(OP_DATA, 16'h0000, 8'h80);
        // Termination with a byte pending, then with nothing pending.
        add_item(OP_TERM, 16'h0000, 8'h00);
        add_item(OP_TERM, 16'hFFFF, 8'hFF);

        // Random: mostly contiguous runs, with noise and broken runs mixed in.
        while (stim_count < TOTAL_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                begin
                    addr = next_addr;
                end
                else if (roll < 50)
                begin
                    addr = 16'hFFF0 + 16'($urandom_range(0, 15));
                end
                else
                begin
                    addr = 16'($urandom_range(0, 65535));
                end
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 20);
                for (int i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        addr = addr + 16'd1;
                    end
                    add_item(OP_DATA, addr, 8'($urandom_range(0, 255)));
                    addr = addr + 16'd1;
                end
                next_addr = addr;
            end
            else if (roll < 72)
            begin
                add_item(($urandom_range(0, 1) == 0) ? OP_OTHER : OP_SPARE,
                         16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            else if (roll < 80)
            begin
                add_item(OP_TERM, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                add_item(OP_DATA, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
        end

        // Reset is held, then released on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every item has been taken and all text has come out.
        @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
        end

        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
